>>> design/particle_update_atlas_step_defines.svh
// assertion helpers shared by the block, clocked on clk and quiet in reset
`ifndef PARTICLE_UPDATE_ATLAS_STEP_DEFINES_SVH
`define PARTICLE_UPDATE_ATLAS_STEP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PUA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pua: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PUA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pua: next-cycle check failed");

`endif

>>> design/pua_pkg.sv
package pua_pkg;

  localparam int DATA_W     = 32;
  localparam int DIST_W     = 64;
  localparam int OFF_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int ROWS_IN_W  = 5;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_ATLAS_ROWS_DEF = 16;

  // latency of the kinematics pipe, in register stages
  localparam int KIN_LAT = 9;

  // quotient bits resolved per divider stage
  localparam int DIV_SPS_WIDE   = 2;
  localparam int DIV_SPS_NARROW = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DELTA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z       = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] gravity;
    logic        [DATA_W-1:0] frame_delta;
    logic signed [DATA_W-1:0] cam_x;
    logic signed [DATA_W-1:0] cam_y;
    logic signed [DATA_W-1:0] cam_z;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]    pos_x;
    logic signed [DATA_W-1:0]    pos_y;
    logic signed [DATA_W-1:0]    pos_z;
    logic signed [DATA_W-1:0]    vel_x;
    logic signed [DATA_W-1:0]    vel_y;
    logic signed [DATA_W-1:0]    vel_z;
    logic signed [DATA_W-1:0]    gravity_weight;
    logic        [DATA_W-1:0]    life_length;
    logic        [DATA_W-1:0]    elapsed;
    logic        [ROWS_IN_W-1:0] atlas_rows;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_y;
    logic        [DIST_W-1:0] dist_sq;
    logic        [OFF_W-1:0]  off1_u;
    logic        [OFF_W-1:0]  off1_v;
    logic        [OFF_W-1:0]  off2_u;
    logic        [OFF_W-1:0]  off2_v;
    logic        [OFF_W-1:0]  blend;
    logic        [DATA_W-1:0] new_elapsed;
    logic                     alive;
  } out_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_y;
    logic        [DIST_W-1:0] dist_sq;
  } kin_res_t;

  // clamp a wide signed value into signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [65:0] v);
    if (v[65:31] == '0 || v[65:31] == '1) begin
      return v[31:0];
    end
    return v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // square of a 33 bit signed difference, all ones once it no longer fits
  function automatic logic [DIST_W-1:0] sq_sat(input logic signed [32:0] d);
    logic [32:0] m;
    m = d[32] ? 33'(-d) : 33'(d);
    if (m[32]) begin
      return '1;
    end
    return 64'(m[31:0]) * 64'(m[31:0]);
  endfunction

  function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = 65'(a) + 65'(b);
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

endpackage

>>> design/pua_if.sv
interface pua_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/pua_dly.sv
module pua_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

>>> design/pua_div.sv
module pua_div #(
  parameter int NW  = 8,
  parameter int DW  = 8,
  parameter int SPS = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int NSTG = (NW + SPS - 1) / SPS;
  localparam int PW   = NSTG * SPS;

  // w holds the dividend bits still to bring down, quotient bits shift in below
  logic [DW-1:0] rem_r [NSTG];
  logic [PW-1:0] w_r   [NSTG];
  logic [DW-1:0] den_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [PW-1:0] w_i;
    logic [DW-1:0] rem_c;
    logic [PW-1:0] w_c;
    logic [DW:0]   t;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign w_i   = PW'(num);
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign w_i   = w_r[s-1];
      assign den_i = den_r[s-1];
    end

    always_comb begin
      rem_c = rem_i;
      w_c   = w_i;
      t     = '0;
      for (int k = 0; k < SPS; k++) begin
        t   = {rem_c, w_c[PW-1]};
        w_c = {w_c[PW-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          rem_c  = DW'(t - {1'b0, den_i});
          w_c[0] = 1'b1;
        end else begin
          rem_c = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        w_r[s]   <= w_c;
        den_r[s] <= den_i;
      end
    end
  end

  assign quo = w_r[NSTG-1][NW-1:0];
  assign rem = rem_r[NSTG-1];

endmodule

>>> design/pua_kin.sv
module pua_kin
  import pua_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  cfg_t     cfg,
  input  in_word_t din,
  output kin_res_t dout
);

  logic signed [32:0] dt_s;
  assign dt_s = $signed({1'b0, cfg.frame_delta});

  // stage 1: gravity product and horizontal motion products
  logic signed [63:0] gp1_r;
  logic signed [64:0] mx1_r, mz1_r;
  logic signed [31:0] px1_r, py1_r, pz1_r, vy1_r;
  // stage 2
  logic signed [31:0] g2_r, nx2_r, nz2_r, py2_r, vy2_r;
  // stage 3
  logic signed [64:0] gm3_r;
  logic signed [32:0] dx3_r, dz3_r;
  logic signed [31:0] nx3_r, nz3_r, py3_r, vy3_r;
  // stage 4
  logic signed [31:0] nvy4_r, nx4_r, nz4_r, py4_r;
  logic        [63:0] sqx4_r, sqz4_r;
  // stage 5
  logic signed [64:0] ym5_r;
  logic        [63:0] sxz5_r;
  logic signed [31:0] nvy5_r, nx5_r, nz5_r, py5_r;
  // stage 6
  logic signed [31:0] ny6_r, nvy6_r, nx6_r, nz6_r;
  logic        [63:0] sxz6_r;
  // stage 7
  logic signed [32:0] dy7_r;
  logic signed [31:0] ny7_r, nvy7_r, nx7_r, nz7_r;
  logic        [63:0] sxz7_r;
  // stage 8
  logic        [63:0] sqy8_r, sxz8_r;
  logic signed [31:0] ny8_r, nvy8_r, nx8_r, nz8_r;
  // stage 9
  kin_res_t           res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gp1_r  <= cfg.gravity * din.gravity_weight;
      mx1_r  <= din.vel_x * dt_s;
      mz1_r  <= din.vel_z * dt_s;
      px1_r  <= din.pos_x;
      py1_r  <= din.pos_y;
      pz1_r  <= din.pos_z;
      vy1_r  <= din.vel_y;

      g2_r   <= sat_s32(66'(gp1_r >>> 16));
      nx2_r  <= sat_s32(66'(px1_r) + 66'(mx1_r >>> 16));
      nz2_r  <= sat_s32(66'(pz1_r) + 66'(mz1_r >>> 16));
      py2_r  <= py1_r;
      vy2_r  <= vy1_r;

      gm3_r  <= g2_r * dt_s;
      dx3_r  <= 33'(cfg.cam_x) - 33'(nx2_r);
      dz3_r  <= 33'(cfg.cam_z) - 33'(nz2_r);
      nx3_r  <= nx2_r;
      nz3_r  <= nz2_r;
      py3_r  <= py2_r;
      vy3_r  <= vy2_r;

      nvy4_r <= sat_s32(66'(vy3_r) + 66'(gm3_r >>> 16));
      sqx4_r <= sq_sat(dx3_r);
      sqz4_r <= sq_sat(dz3_r);
      nx4_r  <= nx3_r;
      nz4_r  <= nz3_r;
      py4_r  <= py3_r;

      ym5_r  <= nvy4_r * dt_s;
      sxz5_r <= add_sat(sqx4_r, sqz4_r);
      nvy5_r <= nvy4_r;
      nx5_r  <= nx4_r;
      nz5_r  <= nz4_r;
      py5_r  <= py4_r;

      ny6_r  <= sat_s32(66'(py5_r) + 66'(ym5_r >>> 16));
      nvy6_r <= nvy5_r;
      nx6_r  <= nx5_r;
      nz6_r  <= nz5_r;
      sxz6_r <= sxz5_r;

      dy7_r  <= 33'(cfg.cam_y) - 33'(ny6_r);
      ny7_r  <= ny6_r;
      nvy7_r <= nvy6_r;
      nx7_r  <= nx6_r;
      nz7_r  <= nz6_r;
      sxz7_r <= sxz6_r;

      sqy8_r <= sq_sat(dy7_r);
      sxz8_r <= sxz7_r;
      ny8_r  <= ny7_r;
      nvy8_r <= nvy7_r;
      nx8_r  <= nx7_r;
      nz8_r  <= nz7_r;

      res_r.new_pos_x <= nx8_r;
      res_r.new_pos_y <= ny8_r;
      res_r.new_pos_z <= nz8_r;
      res_r.new_vel_y <= nvy8_r;
      res_r.dist_sq   <= add_sat(sxz8_r, sqy8_r);
    end
  end

  assign dout = res_r;

endmodule

>>> design/particle_update_atlas_step.sv
// Particle frame step: takes one particle word per cycle and returns it advanced
// by one frame (Euler step with per-particle gravity), with squared camera
// distance, the two texture-atlas cell offsets picked by life fraction, the
// blend between them, the new elapsed time and an alive flag. The depth of the
// pipe is set by the pipelined life-fraction divider, two quotient bits per
// stage over 48 + 2*clog2(MAX_ATLAS_ROWS+1) bits, followed by the cell
// row/column and offset dividers. Throughput is one word per cycle while the
// output buffer is not full; a two-word output buffer keeps the pipe moving
// while a result waits. Configuration writes take effect at once and should
// only be made while the block holds no words.

`include "particle_update_atlas_step_defines.svh"

module particle_update_atlas_step
  import pua_pkg::*;
#(
  parameter int MAX_ATLAS_ROWS = MAX_ATLAS_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data,
  pua_if.sink                  in_ch,
  pua_if.source                out_ch
);

  // widths of the atlas path
  localparam int RW  = $clog2(MAX_ATLAS_ROWS + 1);  // rows
  localparam int SW  = 2 * RW;                      // stages and cell index
  localparam int NNW = DATA_W + SW;                 // elapsed times stages
  localparam int MNW = NNW + FRAC_W;                // dividend with blend bits
  localparam int ONW = RW + FRAC_W;                 // offset dividend

  // stage timing, counted from the input register
  localparam int L1    = (MNW + DIV_SPS_WIDE - 1) / DIV_SPS_WIDE;
  localparam int L2    = (SW + DIV_SPS_WIDE - 1) / DIV_SPS_WIDE;
  localparam int L3    = (ONW + DIV_SPS_NARROW - 1) / DIV_SPS_NARROW;
  localparam int T_A3  = 3 + L1;
  localparam int T_RC  = T_A3 + L2;
  localparam int T_A4  = T_RC + 1;
  localparam int T_END = T_A4 + L3;

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GRAVITY:     cfg_r.gravity     <= cfg_data;
        CFG_FRAME_DELTA: cfg_r.frame_delta <= cfg_data;
        CFG_CAM_X:       cfg_r.cam_x       <= cfg_data;
        CFG_CAM_Y:       cfg_r.cam_y       <= cfg_data;
        CFG_CAM_Z:       cfg_r.cam_z       <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves together; it halts only when the output buffer is full
  logic [1:0]     cnt_r;
  logic           en;
  logic [T_END:0] v_r;
  in_word_t       in_r;

  assign en          = !cnt_r[1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[T_END-1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_ch.data;
    end
  end

  // kinematics and camera distance
  kin_res_t kin_res;
  logic [$bits(kin_res_t)-1:0] kin_end_v;

  pua_kin u_kin (
    .clk  (clk),
    .en   (en),
    .cfg  (cfg_r),
    .din  (in_r),
    .dout (kin_res)
  );

  pua_dly #(.W($bits(kin_res_t)), .DEPTH(T_END - KIN_LAT)) u_kin_dly (
    .clk (clk),
    .en  (en),
    .d   (kin_res),
    .q   (kin_end_v)
  );

  // stage a1: clamp rows, stage count, elapsed update
  logic [RW-1:0]     r_c;
  logic [DATA_W:0]   ne_sum;
  logic [RW-1:0]     r_a1_r;
  logic [SW-1:0]     stg_a1_r;
  logic [DATA_W-1:0] el_a1_r, life_a1_r, ne_a1_r;
  logic              life0_a1_r, ge_a1_r, alive_a1_r;

  always_comb begin
    if (in_r.atlas_rows == '0) begin
      r_c = RW'(1);
    end else if (32'(in_r.atlas_rows) > 32'(MAX_ATLAS_ROWS)) begin
      r_c = RW'(MAX_ATLAS_ROWS);
    end else begin
      r_c = RW'(in_r.atlas_rows);
    end
  end

  assign ne_sum = 33'(in_r.elapsed) + 33'(cfg_r.frame_delta);

  always_ff @(posedge clk) begin
    if (en) begin
      r_a1_r     <= r_c;
      stg_a1_r   <= SW'(r_c) * SW'(r_c);
      el_a1_r    <= in_r.elapsed;
      life_a1_r  <= in_r.life_length;
      life0_a1_r <= (in_r.life_length == '0);
      ge_a1_r    <= (in_r.elapsed >= in_r.life_length);
      ne_a1_r    <= ne_sum[DATA_W] ? '1 : ne_sum[DATA_W-1:0];
      alive_a1_r <= ((ne_sum[DATA_W] ? '1 : ne_sum[DATA_W-1:0]) < in_r.life_length);
    end
  end

  // stage a2: scaled elapsed time
  logic [NNW-1:0]    n_a2_r;
  logic [RW-1:0]     r_a2_r;
  logic [SW-1:0]     stg_a2_r;
  logic [DATA_W-1:0] life_a2_r;
  logic              life0_a2_r, ge_a2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a2_r     <= NNW'(el_a1_r) * NNW'(stg_a1_r);
      r_a2_r     <= r_a1_r;
      stg_a2_r   <= stg_a1_r;
      life_a2_r  <= life_a1_r;
      life0_a2_r <= life0_a1_r;
      ge_a2_r    <= ge_a1_r;
    end
  end

  // life fraction: quotient holds cell index above the blend bits
  logic [MNW-1:0] q_main;

  pua_div #(.NW(MNW), .DW(DATA_W), .SPS(DIV_SPS_WIDE)) u_div_life (
    .clk (clk),
    .en  (en),
    .num ({n_a2_r, {FRAC_W{1'b0}}}),
    .den (life_a2_r),
    .quo (q_main),
    .rem ()
  );

  logic [SW+1:0] ctl_a3;
  logic          life0_a3, ge_a3;
  logic [SW-1:0] stg_a3;
  logic [RW-1:0] r_a3;

  pua_dly #(.W(SW + 2), .DEPTH(L1)) u_ctl_dly (
    .clk (clk),
    .en  (en),
    .d   ({life0_a2_r, ge_a2_r, stg_a2_r}),
    .q   (ctl_a3)
  );

  assign {life0_a3, ge_a3, stg_a3} = ctl_a3;

  pua_dly #(.W(RW), .DEPTH(L1 + 1)) u_r_dly_a3 (
    .clk (clk),
    .en  (en),
    .d   (r_a2_r),
    .q   (r_a3)
  );

  // stage a3: index clamp, zero-life particles pinned to the first cell
  logic [SW-1:0]    idx_c;
  logic [SW-1:0]    idx1_r;
  logic [OFF_W-1:0] blend_a3_r;
  logic             last_a3_r;

  always_comb begin
    if (life0_a3) begin
      idx_c = '0;
    end else if (ge_a3) begin
      idx_c = stg_a3 - SW'(1);
    end else begin
      idx_c = q_main[FRAC_W +: SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r     <= idx_c;
      blend_a3_r <= life0_a3 ? '0 : q_main[FRAC_W-1:0];
      last_a3_r  <= (idx_c == stg_a3 - SW'(1));
    end
  end

  // cell row and column
  logic [SW-1:0] rc_quo;
  logic [RW-1:0] rc_rem;
  logic [RW-1:0] r_rc;
  logic          last_rc;

  pua_div #(.NW(SW), .DW(RW), .SPS(DIV_SPS_WIDE)) u_div_cell (
    .clk (clk),
    .en  (en),
    .num (idx1_r),
    .den (r_a3),
    .quo (rc_quo),
    .rem (rc_rem)
  );

  pua_dly #(.W(RW), .DEPTH(L2)) u_r_dly_rc (
    .clk (clk),
    .en  (en),
    .d   (r_a3),
    .q   (r_rc)
  );

  pua_dly #(.W(1), .DEPTH(L2)) u_last_dly (
    .clk (clk),
    .en  (en),
    .d   (last_a3_r),
    .q   (last_rc)
  );

  // stage a4: second cell follows the first, wrapping to the next row; on the last cell it repeats the first
  logic [RW-1:0] row1_c;
  logic [RW-1:0] col1_r, row1_r, col2_r, row2_r, r_a4_r;

  assign row1_c = rc_quo[RW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      col1_r <= rc_rem;
      row1_r <= row1_c;
      r_a4_r <= r_rc;
      if (last_rc) begin
        col2_r <= rc_rem;
        row2_r <= row1_c;
      end else if (rc_rem == r_rc - RW'(1)) begin
        col2_r <= '0;
        row2_r <= row1_c + RW'(1);
      end else begin
        col2_r <= rc_rem + RW'(1);
        row2_r <= row1_c;
      end
    end
  end

  // cell offsets: column or row over rows as a Q0.16 fraction
  logic [RW-1:0]    ox  [4];
  logic [OFF_W-1:0] off_q [4];

  assign ox[0] = col1_r;
  assign ox[1] = row1_r;
  assign ox[2] = col2_r;
  assign ox[3] = row2_r;

  for (genvar i = 0; i < 4; i++) begin : g_off
    logic [ONW-1:0] q;

    pua_div #(.NW(ONW), .DW(RW), .SPS(DIV_SPS_NARROW)) u_div_off (
      .clk (clk),
      .en  (en),
      .num ({ox[i], {FRAC_W{1'b0}}}),
      .den (r_a4_r),
      .quo (q),
      .rem ()
    );

    assign off_q[i] = q[OFF_W-1:0];
  end

  // fields computed early, lined up with the end of the pipe
  logic [OFF_W-1:0]  blend_end;
  logic [DATA_W:0]   ea_end;

  pua_dly #(.W(OFF_W), .DEPTH(T_END - T_A3)) u_blend_dly (
    .clk (clk),
    .en  (en),
    .d   (blend_a3_r),
    .q   (blend_end)
  );

  pua_dly #(.W(DATA_W + 1), .DEPTH(T_END - 1)) u_elapsed_dly (
    .clk (clk),
    .en  (en),
    .d   ({ne_a1_r, alive_a1_r}),
    .q   (ea_end)
  );

  // result word assembly
  kin_res_t  kin_end;
  out_word_t fin_c;

  assign kin_end = kin_res_t'(kin_end_v);

  always_comb begin
    fin_c.new_pos_x   = kin_end.new_pos_x;
    fin_c.new_pos_y   = kin_end.new_pos_y;
    fin_c.new_pos_z   = kin_end.new_pos_z;
    fin_c.new_vel_y   = kin_end.new_vel_y;
    fin_c.dist_sq     = kin_end.dist_sq;
    fin_c.off1_u      = off_q[0];
    fin_c.off1_v      = off_q[1];
    fin_c.off2_u      = off_q[2];
    fin_c.off2_v      = off_q[3];
    fin_c.blend       = blend_end;
    fin_c.new_elapsed = ea_end[DATA_W:1];
    fin_c.alive       = ea_end[0];
  end

  // two-word output buffer parts the pipe from the consumer
  out_word_t buf_r [2];
  logic      wp_r, rp_r;
  logic      push, pop;
  logic [1:0] cnt_nxt;

  assign push    = en && v_r[T_END];
  assign pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= fin_c;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = buf_r[rp_r];

  `PUA_ASSERT_SAME(a_buf_bound, 1'b1, cnt_r != 2'd3)
  `PUA_ASSERT_NEXT(a_push_shows, push, out_ch.valid)
  `PUA_ASSERT_NEXT(a_stall_holds, !en, $stable(v_r))
  `PUA_ASSERT_NEXT(a_dead_cell, en && life0_a3, idx1_r == '0 && blend_a3_r == '0)

endmodule

>>> dv/tb_particle_update_atlas_step.sv
module tb_particle_update_atlas_step;
  import pua_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  // margin left after the pipe empties, before touching registers
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PER_PHASE = 95;
  localparam int NUM_PHASES = 4;

  // idling styles, one per phase
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0] cfg_data;

  pua_if #(.T(in_word_t))  in_if ();
  pua_if #(.T(out_word_t)) out_if ();

  particle_update_atlas_step u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source)
  );

  // own copy of the block's registers
  logic signed [DATA_W-1:0] reg_gravity;
  logic        [DATA_W-1:0] reg_frame_delta;
  logic signed [DATA_W-1:0] reg_cam_x, reg_cam_y, reg_cam_z;

  out_word_t  pending_words[$];
  stim_row_t  directed_rows[$];
  idle_mode_e idle_mode;
  int unsigned error_count;
  int unsigned cycle_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor: one frame of kinematics plus the atlas lookup
  // ---------------------------------------------------------------------------

  function automatic logic signed [127:0] clamp_s32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // squared axis distance, all ones once the difference leaves 32 bits
  function automatic logic [127:0] axis_dist_sq(input logic signed [127:0] d);
    logic signed [127:0] m;
    m = (d < 0) ? -d : d;
    if (m > 128'sd4294967295) return 128'(64'hFFFF_FFFF_FFFF_FFFF);
    return 128'(m * m);
  endfunction

  function automatic logic [15:0] cell_u(input logic [63:0] idx, input logic [63:0] rows);
    return 16'(((idx % rows) << 16) / rows);
  endfunction

  function automatic logic [15:0] cell_v(input logic [63:0] idx, input logic [63:0] rows);
    return 16'(((idx / rows) << 16) / rows);
  endfunction

  function automatic out_word_t advance_particle(input in_word_t w);
    out_word_t r;
    logic signed [127:0] dt, grav, vy_new, px, py, pz;
    logic [127:0] dsum;
    logic [63:0] rows, stages, n, life, idx1, idx2, bl, nel;
    dt     = 128'(reg_frame_delta);
    grav   = clamp_s32((128'(reg_gravity) * 128'(w.gravity_weight)) >>> 16);
    vy_new = clamp_s32(128'(w.vel_y) + ((grav * dt) >>> 16));
    px     = clamp_s32(128'(w.pos_x) + ((128'(w.vel_x) * dt) >>> 16));
    py     = clamp_s32(128'(w.pos_y) + ((vy_new * dt) >>> 16));
    pz     = clamp_s32(128'(w.pos_z) + ((128'(w.vel_z) * dt) >>> 16));
    r.new_pos_x = px[31:0];
    r.new_pos_y = py[31:0];
    r.new_pos_z = pz[31:0];
    r.new_vel_y = vy_new[31:0];
    // sum saturates, three capped squares cannot wrap 128 bits
    dsum = axis_dist_sq(128'(reg_cam_x) - px) + axis_dist_sq(128'(reg_cam_y) - py)
         + axis_dist_sq(128'(reg_cam_z) - pz);
    r.dist_sq = (dsum > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : dsum[63:0];
    // atlas size is clamped into 1..MAX_ATLAS_ROWS
    rows = 64'(w.atlas_rows);
    if (rows == 0) rows = 1;
    if (rows > 64'(MAX_ATLAS_ROWS_DEF)) rows = 64'(MAX_ATLAS_ROWS_DEF);
    stages = rows * rows;
    life   = 64'(w.life_length);
    if (life == 0) begin
      idx1 = 0;
      bl   = 0;
    end else begin
      n    = 64'(w.elapsed) * stages;
      idx1 = n / life;
      bl   = (((n % life) << 16) / life) & 64'hFFFF;
      if (idx1 > stages - 1) idx1 = stages - 1;
    end
    idx2 = (idx1 < stages - 1) ? idx1 + 1 : idx1;
    r.off1_u = cell_u(idx1, rows);
    r.off1_v = cell_v(idx1, rows);
    r.off2_u = cell_u(idx2, rows);
    r.off2_v = cell_v(idx2, rows);
    r.blend  = bl[15:0];
    nel = 64'(w.elapsed) + 64'(reg_frame_delta);
    if (nel > 64'hFFFF_FFFF) nel = 64'hFFFF_FFFF;
    r.new_elapsed = nel[31:0];
    r.alive = (nel < life);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
    error_count++;
  endtask

  task automatic compare_word(input out_word_t got, input out_word_t want);
    if (got.new_pos_x !== want.new_pos_x)
      report_mismatch("new_pos_x", 64'(got.new_pos_x), 64'(want.new_pos_x));
    if (got.new_pos_y !== want.new_pos_y)
      report_mismatch("new_pos_y", 64'(got.new_pos_y), 64'(want.new_pos_y));
    if (got.new_pos_z !== want.new_pos_z)
      report_mismatch("new_pos_z", 64'(got.new_pos_z), 64'(want.new_pos_z));
    if (got.new_vel_y !== want.new_vel_y)
      report_mismatch("new_vel_y", 64'(got.new_vel_y), 64'(want.new_vel_y));
    if (got.dist_sq !== want.dist_sq)
      report_mismatch("dist_sq", got.dist_sq, want.dist_sq);
    if (got.off1_u !== want.off1_u) report_mismatch("off1_u", 64'(got.off1_u), 64'(want.off1_u));
    if (got.off1_v !== want.off1_v) report_mismatch("off1_v", 64'(got.off1_v), 64'(want.off1_v));
    if (got.off2_u !== want.off2_u) report_mismatch("off2_u", 64'(got.off2_u), 64'(want.off2_u));
    if (got.off2_v !== want.off2_v) report_mismatch("off2_v", 64'(got.off2_v), 64'(want.off2_v));
    if (got.blend !== want.blend) report_mismatch("blend", 64'(got.blend), 64'(want.blend));
    if (got.new_elapsed !== want.new_elapsed)
      report_mismatch("new_elapsed", 64'(got.new_elapsed), 64'(want.new_elapsed));
    if (got.alive !== want.alive) report_mismatch("alive", 64'(got.alive), 64'(want.alive));
  endtask

  // expected word goes in when the input word is taken; a typed row gives its own instead of the predictor's
  bit         next_typed;
  out_word_t  next_want;

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      if (next_typed) pending_words.push_back(next_want);
      else pending_words.push_back(advance_particle(in_if.data));
    end
  end

  // result side: random stall plus the check of each word taken
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (idle_mode)
      IDLE_RECEIVER: out_if.ready <= ($urandom_range(99) >= 83);
      IDLE_BOTH:     out_if.ready <= ($urandom_range(99) >= 37);
      default:       out_if.ready <= 1'b1;
    endcase
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 64'd1, 64'd0);
      end else begin
        compare_word(out_if.data, pending_words.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("FAIL particle_update_atlas_step");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRAVITY:     reg_gravity     = val;
      CFG_FRAME_DELTA: reg_frame_delta = val;
      CFG_CAM_X:       reg_cam_x       = val;
      CFG_CAM_Y:       reg_cam_y       = val;
      CFG_CAM_Z:       reg_cam_z       = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [DATA_W-1:0] g, input logic [DATA_W-1:0] fd,
                           input logic [DATA_W-1:0] cx, input logic [DATA_W-1:0] cy,
                           input logic [DATA_W-1:0] cz);
    write_reg(CFG_GRAVITY, g);
    write_reg(CFG_FRAME_DELTA, fd);
    write_reg(CFG_CAM_X, cx);
    write_reg(CFG_CAM_Y, cy);
    write_reg(CFG_CAM_Z, cz);
  endtask

  // registers only change once the pipe is empty
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one word onto the input channel, held until taken
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 83) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 37)) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    next_typed  <= typed;
    next_want   <= want;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic in_word_t particle(input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] pz, input logic [31:0] vx, input logic [31:0] vy,
      input logic [31:0] vz, input logic [31:0] gw, input logic [31:0] life,
      input logic [31:0] el, input logic [4:0] rows);
    in_word_t w;
    w = '{px, py, pz, vx, vy, vz, gw, life, el, rows};
    return w;
  endfunction

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;  // around +-2
      2: return $urandom_range(32'h0400_0000) - 32'h0200_0000;  // around +-512
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // mostly sane particles, with full-range noise mixed in
  function automatic in_word_t random_particle();
    in_word_t w;
    int m;
    logic [31:0] life;
    m = ($urandom_range(9) < 2) ? 0 : (($urandom_range(19) == 0) ? 3 : $urandom_range(2, 1));
    life = ($urandom_range(9) == 0) ? $urandom() :
           (($urandom_range(19) == 0) ? 32'd0 : $urandom_range(32'h0050_0000, 1));
    w.pos_x = rand_q(m);
    w.pos_y = rand_q(m);
    w.pos_z = rand_q(m);
    w.vel_x = rand_q(m);
    w.vel_y = rand_q(m);
    w.vel_z = rand_q(m);
    w.gravity_weight = ($urandom_range(3) == 0) ? $urandom() : rand_q(1);
    w.life_length = life;
    case ($urandom_range(9))
      0:       w.elapsed = $urandom();
      1:       w.elapsed = life + $urandom_range(32'h0001_0000);
      default: w.elapsed = (life == 0) ? $urandom_range(32'h0001_0000) : $urandom_range(life);
    endcase
    w.atlas_rows = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  task automatic add_row(input in_word_t w, input bit typed, input out_word_t want);
    stim_row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  task automatic build_directed();
    out_word_t zero_word;
    out_word_t dead_word;
    zero_word = '0;
    // zero life length with the clock at its ceiling: first cell, next cell beside it
    dead_word = '0;
    dead_word.off2_u = 16'h1000;
    dead_word.new_elapsed = 32'hFFFF_FFFF;
    // all-zero particle under reset registers
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 5'd1), 1'b1, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 5'd16), 1'b1, dead_word);
    // rows of zero and above the maximum, then three rows
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000, 5'd0), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000, 5'd17), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_7FFF, 5'd31), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0003_0000, 32'h0001_0000, 5'd3), 1'b0, zero_word);
    // index past the end, and sitting exactly on the last stage
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0005_0000, 5'd4), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_FFFF, 5'd16), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16), 1'b0, zero_word);
    add_row(particle(0, 0, 0, 0, 0, 0, 0, 32'd1, 32'hFFFF_FFFF, 5'd16), 1'b0, zero_word);
    // field extremes
    add_row(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h0, 5'd1), 1'b0, zero_word);
    add_row(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                     32'h0000_0001, 5'd2), 1'b0, zero_word);
    add_row(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0002_0000,
                     32'h0001_0000, 5'd15), 1'b0, zero_word);
    add_row(particle(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0010,
                     32'h0000_000F, 5'd8), 1'b0, zero_word);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_GRAVITY;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    next_typed = 1'b0;
    next_want = '0;
    idle_mode = IDLE_NONE;
    error_count = 0;
    cycle_count = 0;
    reg_gravity = '0;
    reg_frame_delta = '0;
    reg_cam_x = '0;
    reg_cam_y = '0;
    reg_cam_z = '0;
    build_directed();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under reset register values
    foreach (directed_rows[i]) send_word(directed_rows[i].word, directed_rows[i].typed,
                                         directed_rows[i].want);
    next_typed <= 1'b0;
    drain_pipe();
    // same table again with gravity and a step on, checked by the predictor
    write_all(32'hFFF6_3333, 32'h0000_0444, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000);
    // junk to a hole in the register map must not disturb anything
    write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
    foreach (directed_rows[i]) send_word(directed_rows[i].word, 1'b0, '0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pipe();
      case (phase)
        0: write_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000);
        1: write_all(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF);
        2: write_all(32'hFFF6_3333, 32'h0000_0444, $urandom_range(32'h0040_0000),
                     $urandom(), $urandom_range(32'h0040_0000));
        default: write_all($urandom(), $urandom_range(32'h0004_0000), $urandom(),
                           $urandom(), $urandom());
      endcase
      idle_mode = idle_mode_e'(phase);
      repeat (RAND_PER_PHASE) send_word(random_particle(), 1'b0, '0);
      // a stretch with no idling at the tail of every phase
      idle_mode = IDLE_NONE;
      repeat (10) send_word(random_particle(), 1'b0, '0);
    end

    drain_pipe();
    if (error_count == 0) begin
      $display("PASS particle_update_atlas_step");
    end else begin
      $display("FAIL particle_update_atlas_step");
    end
    $finish;
  end

endmodule
